// ----- src/idwa_pkg.sv -----
// Package for the inverse distance weight accumulator core.
// Holds widths, saturation bounds and shared types; no dependencies.
`timescale 1ns / 1ps
package idwa_pkg;
    localparam int GRID_POINTS = 16384;
    localparam int IDX_W = 14;
    localparam int SUM_W = 56;
    localparam int D2_W = 36;
    localparam int RAD_W = 52;
    localparam int ROOT_W = 26;
    localparam int W_W = 33;
    localparam int NUM_W = 41;
    localparam int PROD_W = 66;
    localparam logic signed [SUM_W:0] SUM_MAX = 57'sd36028797018963967;
    localparam logic signed [SUM_W:0] SUM_MIN = -57'sd36028797018963968;

    typedef struct packed {
        logic start;
        logic [D2_W-1:0] d2;
    } wcalc_req_t;

    typedef struct packed {
        logic done;
        logic [W_W-1:0] weight;
    } wcalc_rsp_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b,
        input logic signed [SUM_W:0] lo);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s > SUM_MAX) return SUM_MAX[SUM_W-1:0];
        if (s < lo) return lo[SUM_W-1:0];
        return s[SUM_W-1:0];
    endfunction
endpackage

// ----- src/idwa_wcalc.sv -----
// Weight unit: bit-serial square root then bit-serial restoring division.
// Depends on idwa_pkg. Produces floor(2^40 / floor(sqrt(d2 * 2^16))).
`timescale 1ns / 1ps
module idwa_wcalc
(
    input  logic                clk,
    input  logic                rst_n,
    input  idwa_pkg::wcalc_req_t req,
    output idwa_pkg::wcalc_rsp_t rsp
);
    typedef enum logic [2:0] {
        W_IDLE = 3'b001,
        W_SQRT = 3'b010,
        W_DIV  = 3'b100
    } wstate_t;

    wstate_t state_reg;
    logic [5:0] cnt_reg;
    logic [idwa_pkg::RAD_W-1:0] rad_reg;
    logic [idwa_pkg::ROOT_W+1:0] rem_reg;
    logic [idwa_pkg::ROOT_W-1:0] root_reg;
    logic [idwa_pkg::NUM_W-1:0] quo_reg;
    logic [idwa_pkg::ROOT_W:0] drem_reg;
    logic done_reg;

    logic [idwa_pkg::ROOT_W+1:0] trial;
    logic [idwa_pkg::ROOT_W+1:0] rem_sh;
    logic [idwa_pkg::ROOT_W+1:0] dtrial;

    always_comb
    begin
        rem_sh = {rem_reg[idwa_pkg::ROOT_W-1:0], rad_reg[idwa_pkg::RAD_W-1 -: 2]};
        trial = {root_reg, 2'b01};
        dtrial = {drem_reg, quo_reg[idwa_pkg::NUM_W-1]} - {2'b00, root_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                W_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= W_SQRT;
                        cnt_reg <= 6'(idwa_pkg::ROOT_W - 1);
                    end
                end
                W_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= W_DIV;
                        cnt_reg <= 6'(idwa_pkg::NUM_W - 1);
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                W_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= W_IDLE;
                        done_reg <= 1'b1;
                    end
                    else
                        cnt_reg <= cnt_reg - 6'd1;
                end
                default: state_reg <= W_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            W_IDLE:
            begin
                rad_reg <= {req.d2, 16'd0};
                rem_reg <= '0;
                root_reg <= '0;
                quo_reg <= {1'b1, 40'd0};
                drem_reg <= '0;
            end
            W_SQRT:
            begin
                rad_reg <= {rad_reg[idwa_pkg::RAD_W-3:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_reg <= rem_sh - trial;
                    root_reg <= {root_reg[idwa_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    root_reg <= {root_reg[idwa_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            W_DIV:
            begin
                // restoring step: shift in one numerator bit, try subtract
                if (!dtrial[idwa_pkg::ROOT_W+1])
                begin
                    drem_reg <= dtrial[idwa_pkg::ROOT_W:0];
                    quo_reg <= {quo_reg[idwa_pkg::NUM_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= {drem_reg[idwa_pkg::ROOT_W-1:0], quo_reg[idwa_pkg::NUM_W-1]};
                    quo_reg <= {quo_reg[idwa_pkg::NUM_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.weight = quo_reg[idwa_pkg::W_W-1:0];
endmodule

// ----- src/inverse_distance_weight_accumulator_core.sv -----
// Inverse distance weight accumulator core: top level.
// Accept to result runs the distance, root, quotient and multiply/add steps in order.
// One item in flight: s_tready is low from accept until the result beat is taken.
// Throughput is set by the bit-serial root/divide unit, which coincident beats bypass.
// After reset a clearing pass zeroes every store entry; no beat is taken then.
// rst_n is asynchronous, active low, and clears all control state.
`timescale 1ns / 1ps
module inverse_distance_weight_accumulator_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // value_a[31:0], value_b[63:32], sample_x[79:64], sample_y[95:80],
    // sample_z[111:96], point_index[125:112], point_x[141:126],
    // point_y[157:142], point_z[173:158], zero pad to 176
    input  logic [175:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_index[13:0], sum_a[69:14], sum_b[125:70], sum_weight[180:126], pad to 184
    output logic [183:0] m_tdata,
    // zero_distance[0]
    output logic         m_tuser
);
    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_D2    = 9'b000000100,
        S_READ  = 9'b000001000,
        S_WAIT  = 9'b000010000,
        S_MULA  = 9'b000100000,
        S_MULB  = 9'b001000000,
        S_ADD   = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam int IW = idwa_pkg::IDX_W;
    localparam int SW = idwa_pkg::SUM_W;

    state_t state_reg;
    logic [IW:0] clr_reg;
    logic [1:0] dcnt_reg;
    logic signed [31:0] va_reg, vb_reg;
    logic [47:0] spos_reg, ppos_reg;
    logic [IW-1:0] idx_reg;
    logic [idwa_pkg::D2_W-1:0] d2_reg;
    logic signed [SW-1:0] acc_a_reg, acc_b_reg, acc_w_reg;
    logic signed [SW-1:0] pa_reg, pb_reg;
    logic signed [SW-1:0] ra_reg, rb_reg, rw_reg;
    logic zero_reg;
    logic out_valid_reg;

    logic [3*SW-1:0] mem [idwa_pkg::GRID_POINTS];
    logic [3*SW-1:0] rd_reg;

    idwa_pkg::wcalc_req_t wreq;
    idwa_pkg::wcalc_rsp_t wrsp;
    logic [idwa_pkg::W_W-1:0] w_reg;

    logic signed [16:0] diff;
    logic signed [33:0] sq;
    logic signed [31:0] mul_v;
    logic signed [idwa_pkg::PROD_W-1:0] prod;
    logic signed [SW-1:0] prod_sh;

    idwa_wcalc u_wcalc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wreq),
        .rsp   (wrsp)
    );

    // one axis difference per cycle, squared and summed in d2_reg
    always_comb
    begin
        diff = $signed({1'b0, spos_reg[15:0]}) - $signed({1'b0, ppos_reg[15:0]});
        sq = 34'(diff) * 34'(diff);
        mul_v = (state_reg == S_MULA) ? va_reg : vb_reg;
        prod = mul_v * $signed({1'b0, w_reg});
        // arithmetic shift floors toward minus infinity
        prod_sh = SW'(prod >>> 16);
        // start the weight unit only for a nonzero distance
        wreq.start = (state_reg == S_D2) && (dcnt_reg == 2'd3) && (d2_reg != '0);
        wreq.d2 = d2_reg;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {3'd0, rw_reg[SW-2:0], rb_reg, ra_reg, idx_reg};
    assign m_tuser = zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            dcnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg[IW-1:0] == {IW{1'b1}})
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    dcnt_reg <= '0;
                    if (s_tvalid)
                        state_reg <= S_D2;
                end
                S_D2:
                begin
                    dcnt_reg <= dcnt_reg + 2'd1;
                    if (dcnt_reg == 2'd3)
                        state_reg <= S_READ;
                end
                S_READ: state_reg <= zero_reg ? S_ADD : S_WAIT;
                S_WAIT:
                begin
                    if (wrsp.done)
                        state_reg <= S_MULA;
                end
                S_MULA: state_reg <= S_MULB;
                S_MULB: state_reg <= S_ADD;
                S_ADD:
                begin
                    state_reg <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // store port: one write and one registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            mem[clr_reg[IW-1:0]] <= '0;
        else if (state_reg == S_ADD && !zero_reg)
            mem[idx_reg] <= {idwa_pkg::sat_add(acc_w_reg, {{(SW-idwa_pkg::W_W){1'b0}}, w_reg}, '0),
                             idwa_pkg::sat_add(acc_b_reg, pb_reg, idwa_pkg::SUM_MIN),
                             idwa_pkg::sat_add(acc_a_reg, pa_reg, idwa_pkg::SUM_MIN)};
        rd_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                va_reg <= s_tdata[31:0];
                vb_reg <= s_tdata[63:32];
                spos_reg <= s_tdata[111:64];
                idx_reg <= s_tdata[125:112];
                ppos_reg <= s_tdata[173:126];
                d2_reg <= '0;
            end
            S_D2:
            begin
                if (dcnt_reg != 2'd3)
                begin
                    d2_reg <= d2_reg + idwa_pkg::D2_W'($unsigned(sq));
                    spos_reg <= {16'd0, spos_reg[47:16]};
                    ppos_reg <= {16'd0, ppos_reg[47:16]};
                end
                zero_reg <= (d2_reg == '0);
            end
            S_READ: ;
            S_WAIT:
            begin
                acc_a_reg <= rd_reg[SW-1:0];
                acc_b_reg <= rd_reg[2*SW-1:SW];
                acc_w_reg <= rd_reg[3*SW-1:2*SW];
                if (wrsp.done)
                    w_reg <= wrsp.weight;
            end
            S_MULA: pa_reg <= prod_sh;
            S_MULB: pb_reg <= prod_sh;
            S_ADD:
            begin
                if (zero_reg)
                begin
                    ra_reg <= rd_reg[SW-1:0];
                    rb_reg <= rd_reg[2*SW-1:SW];
                    rw_reg <= rd_reg[3*SW-1:2*SW];
                end
                else
                begin
                    ra_reg <= idwa_pkg::sat_add(acc_a_reg, pa_reg, idwa_pkg::SUM_MIN);
                    rb_reg <= idwa_pkg::sat_add(acc_b_reg, pb_reg, idwa_pkg::SUM_MIN);
                    rw_reg <= idwa_pkg::sat_add(acc_w_reg,
                        {{(SW-idwa_pkg::W_W){1'b0}}, w_reg}, '0);
                end
            end
            default: ;
        endcase
    end
endmodule

// ----- src/idwa_checker.sv -----
// Port checker for the inverse distance weight accumulator core.
// Depends on the top level's ports only; attached by bind.
`timescale 1ns / 1ps
module idwa_checker
(
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [183:0] m_tdata,
    input logic m_tuser
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input ready while result pending");
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result dropped");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[183:181] == 3'd0)) else $error("pad bits set");
endmodule

bind inverse_distance_weight_accumulator_core idwa_checker u_idwa_checker
(
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

// ----- dv/idwa_checker.sv -----
// Scoreboard for the inverse distance weight accumulator core.
// Watches both stream channels, predicts each result beat and compares it.
// Depends on idwa_pkg for widths and the store depth.
`timescale 1ns / 1ps
module idwa_scoreboard
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [175:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [183:0] m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending,
    output int           beat_count,
    output int           zero_count,
    output int           clamp_count
);
    typedef struct packed {
        logic [idwa_pkg::IDX_W-1:0]        index;
        logic signed [idwa_pkg::SUM_W-1:0] sum_a;
        logic signed [idwa_pkg::SUM_W-1:0] sum_b;
        logic [idwa_pkg::SUM_W-2:0]        sum_weight;
        logic                              zero;
    } grid_sums_t;

    localparam longint SUM_HI = 64'sd36028797018963967;
    localparam longint SUM_LO = -64'sd36028797018963968;

    longint     sum_a_store [idwa_pkg::GRID_POINTS];
    longint     sum_b_store [idwa_pkg::GRID_POINTS];
    longint     weight_store[idwa_pkg::GRID_POINTS];
    grid_sums_t sums_due[$];

    initial begin
        for (int i = 0; i < idwa_pkg::GRID_POINTS; i++)
        begin
            sum_a_store[i] = 0;
            sum_b_store[i] = 0;
            weight_store[i] = 0;
        end
    end

    function automatic longint unsigned int_root(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Clamp a running sum; count every clamp so the summary can show saturation hits.
    function automatic longint clamp_sum(input longint s, input longint lo);
        if (s > SUM_HI)
        begin
            clamp_count++;
            return SUM_HI;
        end
        if (s < lo)
        begin
            clamp_count++;
            return lo;
        end
        return s;
    endfunction

    function automatic grid_sums_t accumulate(input logic [175:0] d);
        grid_sums_t      r;
        longint          va, vb, dx, dy, dz, w;
        longint unsigned d2, root;
        int              idx;
        va = longint'($signed(d[31:0]));
        vb = longint'($signed(d[63:32]));
        dx = longint'(d[79:64]) - longint'(d[141:126]);
        dy = longint'(d[95:80]) - longint'(d[157:142]);
        dz = longint'(d[111:96]) - longint'(d[173:158]);
        idx = int'(d[125:112]);
        d2 = dx * dx + dy * dy + dz * dz;
        r.index = d[125:112];
        r.zero = (d2 == 0);
        if (d2 != 0)
        begin
            root = int_root(d2 << 16);
            w = longint'((64'd1 << 40) / root);
            sum_a_store[idx] = clamp_sum(sum_a_store[idx] + ((va * w) >>> 16), SUM_LO);
            sum_b_store[idx] = clamp_sum(sum_b_store[idx] + ((vb * w) >>> 16), SUM_LO);
            weight_store[idx] = clamp_sum(weight_store[idx] + w, 0);
        end
        r.sum_a = sum_a_store[idx][idwa_pkg::SUM_W-1:0];
        r.sum_b = sum_b_store[idx][idwa_pkg::SUM_W-1:0];
        r.sum_weight = weight_store[idx][idwa_pkg::SUM_W-2:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        grid_sums_t want, got;
        if (rst_n && s_tvalid && s_tready)
            sums_due = {sums_due, accumulate(s_tdata)};
        if (rst_n && m_tvalid && m_tready)
        begin
            got.index = m_tdata[13:0];
            got.sum_a = m_tdata[69:14];
            got.sum_b = m_tdata[125:70];
            got.sum_weight = m_tdata[180:126];
            got.zero = m_tuser;
            beat_count++;
            if (got.zero)
                zero_count++;
            if (sums_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result beat index=%0d", $realtime, got.index);
            end
            else
            begin
                want = sums_due.pop_front();
                if (want != got)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: mismatch exp idx=%0d a=%0d b=%0d w=%0d z=%0b",
                                 $realtime, want.index, want.sum_a, want.sum_b,
                                 want.sum_weight, want.zero);
                        $display("%0t:          got idx=%0d a=%0d b=%0d w=%0d z=%0b",
                                 $realtime, got.index, got.sum_a, got.sum_b,
                                 got.sum_weight, got.zero);
                    end
                end
            end
        end
        pending = sums_due.size();
    end
endmodule

// ----- dv/tb.sv -----
// Top of the testbench for the inverse distance weight accumulator core.
// Drives sample/point beats, stalls the result side and gives the verdict.
// Depends on idwa_pkg, the core RTL and idwa_scoreboard.
`timescale 1ns / 1ps
module tb;
    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;
    logic         m_tuser;
    int           fail_count, pending, beat_count, zero_count, clamp_count;
    bit           hold_req;   // ask the receiver for one long hold-off
    bit           burst;      // no idling on either side while set
    int           sent;

    inverse_distance_weight_accumulator_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    idwa_scoreboard chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending), .beat_count(beat_count),
        .zero_count(zero_count), .clamp_count(clamp_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Bound on the run: clearing pass plus ~700 beats, many times over.
    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random gaps before each beat, one long hold-off on request.
    initial
    begin
        int n;
        m_tready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                // hold off long enough for the sender to see s_tready stay low
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                n = burst ? 0 : $urandom_range(0, 3);
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                m_tready <= 1'b1;
            end
            // advance until a beat is taken
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic logic [175:0] pack_beat(
        input logic [31:0] va, input logic [31:0] vb,
        input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] sz,
        input logic [idwa_pkg::IDX_W-1:0] idx,
        input logic [15:0] px, input logic [15:0] py, input logic [15:0] pz);
        return {2'b00, pz, py, px, idx, sz, sy, sx, vb, va};
    endfunction

    // Offer one beat after a random gap; hold it until accepted.
    task automatic send_beat(input logic [175:0] d);
        int n;
        n = burst ? 0 : $urandom_range(0, 3);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] near(input logic [15:0] p);
        int v;
        v = int'(p) + int'($urandom_range(0, 64)) - 32;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 255)) - 128);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random();
        logic [15:0]                sx, sy, sz, px, py, pz;
        logic [idwa_pkg::IDX_W-1:0] idx;
        int                         shape;
        sx = 16'($urandom); sy = 16'($urandom); sz = 16'($urandom);
        // mostly a few hot grid points so sums build up, sometimes any point
        idx = ($urandom_range(0, 9) < 7) ? idwa_pkg::IDX_W'($urandom_range(0, 7))
                                         : idwa_pkg::IDX_W'($urandom);
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            px = sx; py = sy; pz = sz;              // coincident: no update
        end
        else if (shape < 6)
        begin
            px = near(sx); py = near(sy); pz = near(sz);
        end
        else
        begin
            px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
        end
        send_beat(pack_beat(rand_value(), rand_value(), sx, sy, sz, idx, px, py, pz));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        hold_req = 1'b0;
        burst = 1'b0;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes of values and positions, both index ends, coincidence.
        send_beat(pack_beat(32'h7fff_ffff, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 14'd0,
                            16'd0, 16'd0, 16'd1));           // minimum distance, max weight
        send_beat(pack_beat(32'h7fff_ffff, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 14'd0,
                            16'hffff, 16'hffff, 16'hffff));  // maximum distance
        send_beat(pack_beat(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 16'hffff, 16'hffff,
                            14'h3fff, 16'd0, 16'd0, 16'd0));
        send_beat(pack_beat(32'h0000_0001, 32'hffff_ffff, 16'h1234, 16'h5678, 16'h9abc,
                            14'h3fff, 16'h1234, 16'h5678, 16'h9abc)); // coincident
        send_beat(pack_beat(32'd0, 32'd0, 16'h1234, 16'h5678, 16'h9abc,
                            14'd0, 16'h1234, 16'h5678, 16'h9abc));    // coincident, sums kept
        send_beat(pack_beat(32'hffff_ffff, 32'h0001_0000, 16'h8000, 16'h0000, 16'h0000,
                            14'h2aaa, 16'h0000, 16'h8000, 16'h0000));
        send_beat(pack_beat(32'h5555_5555, 32'haaaa_aaaa, 16'h00ff, 16'hff00, 16'h0f0f,
                            14'h1555, 16'hff00, 16'h00ff, 16'hf0f0));
        send_beat(pack_beat(32'd0, 32'd0, 16'd5, 16'd5, 16'd5, 14'h1555,
                            16'd5, 16'd6, 16'd5));           // zero values, sum of weight only
        for (int i = 0; i < 8; i++)
            send_beat(pack_beat($urandom, $urandom, 16'h4000, 16'h4000, 16'h4000, 14'd3,
                                16'(16'h4000 + i), 16'h4001, 16'(16'h4000 - i)));
        drain();    // sender pause until every result is back

        // Saturation: max weight into one point, positive and negative sums clamp.
        burst = 1'b1;
        for (int i = 0; i < 270; i++)
        begin
            if (i == 20)
                hold_req = 1'b1;    // long receiver stall while the sender keeps offering a beat
            send_beat(pack_beat(32'h7fff_ffff, 32'h8000_0000, 16'd100, 16'd100, 16'd100,
                                14'd77, 16'd100, 16'd100, 16'd101));
        end
        burst = 1'b0;

        // Random mix, with short bursts of back-to-back traffic.
        for (int i = 0; i < 370; i++)
        begin
            if (i % 60 == 0)
                burst = ~burst;
            send_random();
        end
        burst = 1'b0;
        drain();
        repeat (100) @(posedge clk);

        $display("Sent %0d beats, checked %0d results, %0d coincident, %0d saturating adds.",
                 sent, beat_count, zero_count, clamp_count);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
